/* hw/rtl/sipl_pkg.sv */
`default_nettype none

package sipl_pkg;

    localparam int POS_W   = 40;
    localparam int FWD_W   = 39;
    localparam int MAXH_W  = 7;
    localparam int SEED_W  = 10;
    localparam int RANK_W  = 10;
    localparam int WIDTH_W = 11;
    localparam int SLEN_W  = 11;
    localparam int IDX_W   = 6;
    localparam int K_W     = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 39;

    localparam logic [MAXH_W-1:0] HIT_CAP       = 7'd64;
    localparam logic [MAXH_W-1:0] MAX_HITS_INIT = 7'd64;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HITS       = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_SCAN,
        S_UNIQ,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic               opcode;
        logic [RANK_W-1:0]  table_addr;
        logic [POS_W-1:0]   table_value;
        logic [SEED_W-1:0]  seed_start;
        logic [SEED_W-1:0]  seed_end;
        logic               reverse_strand;
        logic               unique_seed;
        logic [POS_W-1:0]   unique_position;
        logic [WIDTH_W-1:0] interval_width;
        logic [RANK_W-1:0]  interval_low;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0] hit_position;
        logic             hit_valid;
        logic [IDX_W-1:0] hit_index;
        logic             last_in_run;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/sipl_if.sv */
`default_nettype none

interface sipl_item_if import sipl_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sipl_result_if import sipl_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sipl_ram.sv */
`default_nettype none

module sipl_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sipl_div.sv */
`default_nettype none

// restoring divider, one quotient bit per cycle
module sipl_div import sipl_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [WIDTH_W-1:0] dividend,
    input  wire logic [MAXH_W-1:0]  divisor,
    output logic                    busy,
    output logic      [WIDTH_W-1:0] quotient
);

    localparam int CNT_W = $clog2(WIDTH_W + 1);

    logic [MAXH_W-1:0]  rem_reg, rem_next;
    logic [WIDTH_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [MAXH_W:0]    trial;
    logic [MAXH_W:0]    diff;
    logic               fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[WIDTH_W-1]};
        diff      = trial - {1'b0, divisor};
        fits      = trial >= {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(WIDTH_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor, so it fits in MAXH_W bits
            rem_next  = fits ? diff[MAXH_W-1:0] : trial[MAXH_W-1:0];
            quo_next  = {quo_reg[WIDTH_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* hw/rtl/sipl_hit_check.sv */
`default_nettype none

// lim = 2*forward_length - slen; a raw position r is a hit when lim_ok is set and r <= lim
module sipl_hit_check import sipl_pkg::*; (
    input  wire logic [POS_W-1:0] raw,
    input  wire logic [POS_W-1:0] lim,
    input  wire logic             lim_ok,
    input  wire logic             rev,
    output logic                  ok,
    output logic      [POS_W-1:0] pos
);

    always_comb
    begin
        ok  = lim_ok && (raw <= lim);
        pos = rev ? (lim - raw) : raw;
    end

endmodule

`default_nettype wire

/* hw/rtl/seed_interval_position_lookup.sv */
// Seed interval position lookup.
// item channel (valid/ready): opcode OP_WRITE stores table_value at rank
// table_addr of the suffix table (ranks at or beyond TABLE_DEPTH are dropped);
// opcode OP_QUERY looks up one seed. result channel (valid/ready) carries one
// transaction per hit, the final one flagged last_in_run; a query without hits
// gives a single transaction with hit_valid low.
// cfg port: cfg_we/cfg_index/cfg_data write forward_length (index 0) and
// max_hits (index 1); write only while no query is in flight.
// Sequence: a write is stored while the item channel stays ready. A query runs
// setup, then the stride divide when interval_width exceeds the hit cap
// (max_hits, at most 64), then the scan of sampled ranks via the registered table
// read, then the closing flush; a unique seed runs setup, one check, flush. The
// single table read port sets the one-rank-per-cycle scan unless the receiver stalls.
// The item channel is not ready while a query runs; it is ready again while
// the last result still waits in the output register.
// When the receiver stalls, the scan pauses with at most one hit held
// internally and one in the output register; nothing is dropped.
// Reset clears control state and sets forward_length to 0 and max_hits to 64;
// suffix table contents are undefined until written.
`default_nettype none

module seed_interval_position_lookup import sipl_pkg::*; #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    sipl_item_if.sink                  item,
    sipl_result_if.source              result
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CMP_W = (AW + 1 > K_W) ? AW + 1 : K_W;

    state_t             state_reg, state_next;
    logic [FWD_W-1:0]   fwd_reg, fwd_next;
    logic [MAXH_W-1:0]  maxh_reg, maxh_next;
    logic [SLEN_W-1:0]  slen_reg, slen_next;
    logic               rev_reg, rev_next;
    logic               uniq_reg, uniq_next;
    logic [POS_W-1:0]   upos_reg, upos_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic [RANK_W-1:0]  low_reg, low_next;
    logic [POS_W-1:0]   lim_reg, lim_next;
    logic               lim_ok_reg, lim_ok_next;
    logic [WIDTH_W-1:0] step_reg, step_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [MAXH_W-1:0]  n_reg, n_next;
    logic               b_valid_reg, b_valid_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [POS_W-1:0]   pend_pos_reg, pend_pos_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic [MAXH_W-1:0]  cap;
    logic               item_fire;
    logic               out_free;
    logic               adv;
    logic [K_W-1:0]     rank;
    logic [CMP_W-1:0]   rank_ext;
    logic [CMP_W-1:0]   taddr_ext;
    logic               rank_in_range;
    logic               issue_ok;
    logic               scan_done;
    logic               hit_fire;
    logic [POS_W:0]     lim_wide;
    logic [POS_W-1:0]   ram_rdata;
    logic               ram_we;
    logic               ram_re;
    logic [POS_W-1:0]   chk_raw;
    logic               chk_ok;
    logic [POS_W-1:0]   chk_pos;
    logic               div_start;
    logic               div_busy;
    logic [WIDTH_W-1:0] div_quo;

    assign cap       = (maxh_reg > HIT_CAP) ? HIT_CAP : maxh_reg;
    assign item.ready = (state_reg == S_IDLE);
    assign item_fire = item.valid && item.ready;
    assign out_free  = !out_valid_reg || result.ready;
    // a new hit pushes the held one out, so stall the scan when that cannot happen
    assign adv       = out_free || !pend_valid_reg;

    assign rank          = K_W'(low_reg) + k_reg;
    assign rank_ext      = CMP_W'(rank);
    assign taddr_ext     = CMP_W'(item.payload.table_addr);
    assign rank_in_range = rank_ext < CMP_W'(TABLE_DEPTH);
    assign issue_ok      = (state_reg == S_SCAN) && adv
                           && (k_reg < K_W'(width_reg)) && (n_reg < cap);
    assign scan_done     = (n_reg >= cap) || ((k_reg >= K_W'(width_reg)) && !b_valid_reg);

    assign ram_we  = item_fire && (item.payload.opcode == OP_WRITE)
                     && (taddr_ext < CMP_W'(TABLE_DEPTH));
    assign ram_re  = issue_ok && rank_in_range;
    assign chk_raw = (state_reg == S_UNIQ) ? upos_reg : ram_rdata;

    assign hit_fire = chk_ok && (((state_reg == S_SCAN) && b_valid_reg && adv && (n_reg < cap))
                      || (state_reg == S_UNIQ));

    assign lim_wide  = {1'b0, fwd_reg, 1'b0} - (POS_W + 1)'(slen_reg);
    assign div_start = (state_reg == S_SETUP) && (cap != '0) && !uniq_reg
                       && (width_reg != '0) && (width_reg > WIDTH_W'(cap));

    sipl_ram #(
        .WIDTH (POS_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (taddr_ext[AW-1:0]),
        .wdata (item.payload.table_value),
        .re    (ram_re),
        .raddr (rank_ext[AW-1:0]),
        .rdata (ram_rdata)
    );

    sipl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (width_reg),
        .divisor  (cap),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    sipl_hit_check u_check (
        .raw    (chk_raw),
        .lim    (lim_reg),
        .lim_ok (lim_ok_reg),
        .rev    (rev_reg),
        .ok     (chk_ok),
        .pos    (chk_pos)
    );

    always_comb
    begin
        state_next      = state_reg;
        fwd_next        = fwd_reg;
        maxh_next       = maxh_reg;
        slen_next       = slen_reg;
        rev_next        = rev_reg;
        uniq_next       = uniq_reg;
        upos_next       = upos_reg;
        width_next      = width_reg;
        low_next        = low_reg;
        lim_next        = lim_reg;
        lim_ok_next     = lim_ok_reg;
        step_next       = step_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        b_valid_next    = b_valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_next        = out_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FORWARD_LENGTH: fwd_next  = cfg_data[FWD_W-1:0];
                CFG_MAX_HITS:       maxh_next = cfg_data[MAXH_W-1:0];
                default:            ;
            endcase
        end

        if (hit_fire)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next           = 1'b1;
                out_next.hit_position    = pend_pos_reg;
                out_next.hit_valid       = 1'b1;
                out_next.hit_index       = pend_idx_reg;
                out_next.last_in_run     = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_pos_next   = chk_pos;
            pend_idx_next   = n_reg[IDX_W-1:0];
            n_next          = n_reg + 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire && (item.payload.opcode == OP_QUERY))
                begin
                    slen_next    = (item.payload.seed_end >= item.payload.seed_start)
                                   ? SLEN_W'(item.payload.seed_end - item.payload.seed_start)
                                     + 1'b1
                                   : '0;
                    rev_next     = item.payload.reverse_strand;
                    uniq_next    = item.payload.unique_seed;
                    upos_next    = item.payload.unique_position;
                    width_next   = item.payload.interval_width;
                    low_next     = item.payload.interval_low;
                    k_next       = '0;
                    n_next       = '0;
                    b_valid_next = 1'b0;
                    step_next    = WIDTH_W'(1);
                    state_next   = S_SETUP;
                end
            end
            S_SETUP:
            begin
                lim_next    = lim_wide[POS_W-1:0];
                lim_ok_next = !lim_wide[POS_W] && (slen_reg != '0);
                if (cap == '0)
                begin
                    state_next = S_FLUSH;
                end
                else if (uniq_reg)
                begin
                    state_next = S_UNIQ;
                end
                else if (width_reg == '0)
                begin
                    state_next = S_FLUSH;
                end
                else if (div_start)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    step_next  = div_quo;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    b_valid_next = 1'b0;
                    state_next   = S_FLUSH;
                end
                else if (adv)
                begin
                    b_valid_next = issue_ok && rank_in_range;
                    if (issue_ok)
                    begin
                        k_next = k_reg + K_W'(step_reg);
                    end
                end
            end
            S_UNIQ:
            begin
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.hit_position = pend_valid_reg ? pend_pos_reg : '0;
                    out_next.hit_valid   = pend_valid_reg;
                    out_next.hit_index   = pend_valid_reg ? pend_idx_reg : '0;
                    out_next.last_in_run = 1'b1;
                    pend_valid_next      = 1'b0;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fwd_reg        <= '0;
            maxh_reg       <= MAX_HITS_INIT;
            n_reg          <= '0;
            b_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fwd_reg        <= fwd_next;
            maxh_reg       <= maxh_next;
            n_reg          <= n_next;
            b_valid_reg    <= b_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slen_reg     <= slen_next;
        rev_reg      <= rev_next;
        uniq_reg     <= uniq_next;
        upos_reg     <= upos_next;
        width_reg    <= width_next;
        low_reg      <= low_next;
        lim_reg      <= lim_next;
        lim_ok_reg   <= lim_ok_next;
        step_reg     <= step_next;
        k_reg        <= k_next;
        pend_pos_reg <= pend_pos_next;
        pend_idx_reg <= pend_idx_next;
        out_reg      <= out_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

endmodule

`default_nettype wire

/* hw/rtl/sipl_checker.sv */
`default_nettype none

module sipl_checker import sipl_pkg::*; (
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_ready,
    input wire logic    item_opcode,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire result_t result_payload
);

    // a stalled result transaction keeps its contents
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_payload))
        else $error("result changed while stalled");

    // a table write leaves the item channel ready
    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_opcode == OP_WRITE) |=> item_ready)
        else $error("not ready after a table write");

    // a query holds off further items while it runs
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_opcode == OP_QUERY) |=> !item_ready)
        else $error("ready right after a query");

    // the no-hit marker stands alone and closes its run
    a_nohit_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_payload.hit_valid |->
            result_payload.last_in_run && (result_payload.hit_index == '0)
            && (result_payload.hit_position == '0))
        else $error("malformed no-hit transaction");

endmodule

bind seed_interval_position_lookup sipl_checker u_sipl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_opcode    (item.payload.opcode),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
);

`default_nettype wire
